/* rtl/lwcl_pkg.sv */
// Shared types and constants for the link watchdog and command latch.
// Holds the configuration, request and result structs and register indexes.
// No dependencies.
package lwcl_pkg;

  localparam int TIME_WIDTH = 32;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_LENGTH      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRESH_TIMEOUT     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFLINE_PERIOD    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFLINE_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_WINDOW       = 3'd4;

  // Reset values of the configuration registers
  localparam logic [6:0]  RST_FRAME_LENGTH      = 7'd11;
  localparam logic [15:0] RST_FRESH_TIMEOUT     = 16'd100;
  localparam logic [15:0] RST_OFFLINE_PERIOD    = 16'd100;
  localparam logic [7:0]  RST_OFFLINE_THRESHOLD = 8'd10;
  localparam logic [15:0] RST_RATE_WINDOW       = 16'd1000;

  // Frame framing bytes
  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;

  // Request mode codes
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

  typedef struct packed {
    logic [6:0]  frame_length;
    logic [15:0] fresh_timeout;
    logic [15:0] offline_period;
    logic [7:0]  offline_threshold;
    logic [15:0] rate_window;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [6:0]  frame_len;
    logic [7:0]  frame_start;
    logic [7:0]  frame_end;
    logic [31:0] frame_vx;
    logic [31:0] frame_wz;
    logic [7:0]  frame_capture;
  } item_t;

  typedef struct packed {
    logic        frame_accepted;
    logic        link_online;
    logic [31:0] cmd_vx;
    logic [31:0] cmd_wz;
    logic        cmd_capture;
    logic        cmd_fresh;
    logic [15:0] frame_rate;
  } result_t;

endpackage

/* rtl/lwcl_cfg.sv */
// Configuration register file for the link watchdog.
// Depends on lwcl_pkg for the register indexes, reset values and cfg_t.
module lwcl_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [lwcl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lwcl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output lwcl_pkg::cfg_t                       cfg
);
  import lwcl_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_length      <= RST_FRAME_LENGTH;
      regs.fresh_timeout     <= RST_FRESH_TIMEOUT;
      regs.offline_period    <= RST_OFFLINE_PERIOD;
      regs.offline_threshold <= RST_OFFLINE_THRESHOLD;
      regs.rate_window       <= RST_RATE_WINDOW;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_FRAME_LENGTH:      regs.frame_length      <= cfg_data[6:0];
        REG_FRESH_TIMEOUT:     regs.fresh_timeout     <= cfg_data;
        REG_OFFLINE_PERIOD:    regs.offline_period    <= cfg_data;
        REG_OFFLINE_THRESHOLD: regs.offline_threshold <= cfg_data[7:0];
        REG_RATE_WINDOW:       regs.rate_window       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* rtl/lwcl_core.sv */
// Watchdog state and single-pass update logic for one request.
// Depends on lwcl_pkg for cfg_t, item_t, result_t and the framing constants.
module lwcl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  lwcl_pkg::item_t   item,
  input  lwcl_pkg::cfg_t    cfg,
  output lwcl_pkg::result_t result
);
  import lwcl_pkg::*;

  logic [TIME_WIDTH-1:0] tick_time, tick_time_next;
  logic [TIME_WIDTH-1:0] last_update, last_update_next;
  logic                  cmd_valid, cmd_valid_next;
  logic                  seen_frame, seen_frame_next;
  logic                  online_flag, online_flag_next;
  logic [31:0]           held_vx, held_vx_next;
  logic [31:0]           held_wz, held_wz_next;
  logic                  held_capture, held_capture_next;
  logic [15:0]           silence_timer, silence_timer_next;
  logic [7:0]            silence_count, silence_count_next;
  logic [15:0]           window_timer, window_timer_next;
  logic [15:0]           window_frames, window_frames_next;
  logic [15:0]           last_rate, last_rate_next;

  always_comb begin
    logic                  frame_ok;
    logic [15:0]           wt_inc;
    logic [15:0]           st_inc;
    logic [7:0]            sc_inc;
    logic [TIME_WIDTH-1:0] age;

    tick_time_next     = tick_time;
    last_update_next   = last_update;
    cmd_valid_next     = cmd_valid;
    seen_frame_next    = seen_frame;
    online_flag_next   = online_flag;
    held_vx_next       = held_vx;
    held_wz_next       = held_wz;
    held_capture_next  = held_capture;
    silence_timer_next = silence_timer;
    silence_count_next = silence_count;
    window_timer_next  = window_timer;
    window_frames_next = window_frames;
    last_rate_next     = last_rate;

    frame_ok = (item.frame_len != 7'd0) && (item.frame_len == cfg.frame_length) &&
               (item.frame_start == HDR_BYTE) && (item.frame_end == TAIL_BYTE) &&
               (item.frame_capture <= 8'd1);
    wt_inc = window_timer + 16'd1;
    st_inc = silence_timer + 16'd1;
    sc_inc = (silence_count < cfg.offline_threshold) ? silence_count + 8'd1 : silence_count;

    if (item.mode == MODE_TICK) begin
      tick_time_next = tick_time + TIME_WIDTH'(1);
      // close the rate window
      if (wt_inc >= cfg.rate_window) begin
        last_rate_next     = window_frames;
        window_frames_next = 16'd0;
        window_timer_next  = 16'd0;
      end else begin
        window_timer_next = wt_inc;
      end
      if (seen_frame) begin
        seen_frame_next    = 1'b0;
        silence_timer_next = 16'd0;
        silence_count_next = 8'd0;
        online_flag_next   = 1'b1;
      end else if (st_inc < cfg.offline_period) begin
        silence_timer_next = st_inc;
      end else begin
        silence_timer_next = 16'd0;
        silence_count_next = sc_inc;
        // drop the link and clear the command at threshold
        if (!(sc_inc < cfg.offline_threshold)) begin
          held_vx_next      = 32'd0;
          held_wz_next      = 32'd0;
          held_capture_next = 1'b0;
          last_update_next  = '0;
          cmd_valid_next    = 1'b0;
          online_flag_next  = 1'b0;
        end
      end
    end else if (frame_ok) begin
      last_update_next  = tick_time;
      seen_frame_next   = 1'b1;
      online_flag_next  = 1'b1;
      held_vx_next      = item.frame_vx;
      held_wz_next      = item.frame_wz;
      held_capture_next = item.frame_capture[0];
      cmd_valid_next    = 1'b1;
      if (window_frames != FRAMES_MAX) begin
        window_frames_next = window_frames + 16'd1;
      end
    end

    age = tick_time_next - last_update_next;

    result.frame_accepted = (item.mode == MODE_FRAME) && frame_ok;
    result.link_online    = online_flag_next;
    result.cmd_vx         = held_vx_next;
    result.cmd_wz         = held_wz_next;
    result.cmd_capture    = held_capture_next;
    result.cmd_fresh      = cmd_valid_next && (age <= TIME_WIDTH'(cfg.fresh_timeout));
    result.frame_rate     = last_rate_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time     <= '0;
      last_update   <= '0;
      cmd_valid     <= 1'b0;
      seen_frame    <= 1'b0;
      online_flag   <= 1'b0;
      held_vx       <= 32'd0;
      held_wz       <= 32'd0;
      held_capture  <= 1'b0;
      silence_timer <= 16'd0;
      silence_count <= 8'd0;
      window_timer  <= 16'd0;
      window_frames <= 16'd0;
      last_rate     <= 16'd0;
    end else if (advance) begin
      tick_time     <= tick_time_next;
      last_update   <= last_update_next;
      cmd_valid     <= cmd_valid_next;
      seen_frame    <= seen_frame_next;
      online_flag   <= online_flag_next;
      held_vx       <= held_vx_next;
      held_wz       <= held_wz_next;
      held_capture  <= held_capture_next;
      silence_timer <= silence_timer_next;
      silence_count <= silence_count_next;
      window_timer  <= window_timer_next;
      window_frames <= window_frames_next;
      last_rate     <= last_rate_next;
    end
  end

endmodule

/* rtl/link_watchdog_command_latch.sv */
// Top level of the link watchdog and command latch.
// Depends on lwcl_pkg, lwcl_cfg and lwcl_core.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   request   | req_valid, req_stall | mode, frame_len, frame_start, frame_end,
//             |                      | frame_vx, frame_wz, frame_capture
//   result    | rsp_valid, rsp_stall | frame_accepted, link_online, cmd_vx,
//             |                      | cmd_wz, cmd_capture, cmd_fresh, frame_rate
//   config    | cfg_wen              | cfg_index, cfg_data
//
// Each request passes from the request register into the result register, where
// its result becomes valid. The watchdog update between them is a single pass,
// so one request is accepted every cycle while rsp_stall is low.
// Synchronous active-high rst clears all control and watchdog state, loads the
// register reset values and needs no clearing pass.
// A stalled result holds in the result register while one more request is
// taken into the request register; req_stall rises only once both are full.
module link_watchdog_command_latch (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_wen,
  input  logic [lwcl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lwcl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic                                 mode,
  input  logic [6:0]                           frame_len,
  input  logic [7:0]                           frame_start,
  input  logic [7:0]                           frame_end,
  input  logic [31:0]                          frame_vx,
  input  logic [31:0]                          frame_wz,
  input  logic [7:0]                           frame_capture,
  // result channel
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic                                 frame_accepted,
  output logic                                 link_online,
  output logic [31:0]                          cmd_vx,
  output logic [31:0]                          cmd_wz,
  output logic                                 cmd_capture,
  output logic                                 cmd_fresh,
  output logic [15:0]                          frame_rate
);
  import lwcl_pkg::*;

  cfg_t    cfg;
  item_t   req_item;
  logic    req_full;
  result_t core_result;
  result_t rsp_data;
  logic    rsp_full;
  logic    rsp_free;
  logic    advance;
  logic    req_take;

  lwcl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register frees when empty or when its result is taken;
  // the held request advances into it and updates the watchdog state.
  assign rsp_free  = !rsp_full || !rsp_stall;
  assign advance   = req_full && rsp_free;
  assign req_stall = req_full && !rsp_free;
  assign req_take  = req_valid && !req_stall;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_take) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_item.mode          <= mode;
      req_item.frame_len     <= frame_len;
      req_item.frame_start   <= frame_start;
      req_item.frame_end     <= frame_end;
      req_item.frame_vx      <= frame_vx;
      req_item.frame_wz      <= frame_wz;
      req_item.frame_capture <= frame_capture;
    end
  end

  lwcl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (req_item),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (rsp_free) begin
      rsp_full <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= core_result;
    end
  end

  assign rsp_valid      = rsp_full;
  assign frame_accepted = rsp_data.frame_accepted;
  assign link_online    = rsp_data.link_online;
  assign cmd_vx         = rsp_data.cmd_vx;
  assign cmd_wz         = rsp_data.cmd_wz;
  assign cmd_capture    = rsp_data.cmd_capture;
  assign cmd_fresh      = rsp_data.cmd_fresh;
  assign frame_rate     = rsp_data.frame_rate;

`ifndef SYNTHESIS
  // An accepted frame always leaves the link online with a fresh command.
  a_accept_online_fresh: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && frame_accepted |-> link_online && cmd_fresh)
    else $error("accepted frame without online link or fresh command");

  // Stall only while a request is held.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> req_full)
    else $error("request stall with empty request register");

  // A held request that cannot advance stays held.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_full && !rsp_free |=> req_full)
    else $error("held request lost");

  // A result enters the register only from an advancing request.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rsp_valid) |-> $past(advance))
    else $error("result without source request");
`endif

endmodule
